/* design/nfsd_pkg.sv */
// Shared types and constants for the next-free-server dispatcher.
package nfsd_pkg;

    localparam int COUNT_W = 32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam int ACTIVE_W = 6;
    localparam int SRVN_W = 7;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 6'd32;
    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_ACTIVE = 3'd0;

    typedef struct packed {
        logic [4:0]  preferred_server;
        logic [31:0] arrival_time;
        logic [31:0] service_length;
    } in_word_t;

    typedef struct packed {
        logic        served;
        logic [4:0]  assigned_server;
        logic [31:0] top_count;
        logic [31:0] leader_mask;
    } out_word_t;

endpackage

/* design/nfsd_store.sv */
// Server state memory: busy-until and call count per server, with reset valid bits.
module nfsd_store
    import nfsd_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int IW    = 5,
    parameter int TW    = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_en,
    input  logic               req_we,
    input  logic [IW-1:0]      req_addr,
    input  logic [TW-1:0]      wr_busy,
    input  logic [COUNT_W-1:0] wr_count,
    output logic [TW-1:0]      rd_busy,
    output logic [COUNT_W-1:0] rd_count
);

    logic [TW-1:0]      busy_mem  [DEPTH];
    logic [COUNT_W-1:0] count_mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    logic               rd_valid_reg;
    logic [TW-1:0]      rd_busy_reg;
    logic [COUNT_W-1:0] rd_count_reg;

    always_ff @(posedge clk)
    begin
        if (req_en && req_we)
        begin
            busy_mem[req_addr]  <= wr_busy;
            count_mem[req_addr] <= wr_count;
        end
        if (req_en && !req_we)
        begin
            rd_busy_reg  <= busy_mem[req_addr];
            rd_count_reg <= count_mem[req_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_en && req_we)
            begin
                valid_reg[req_addr] <= 1'b1;
            end
            if (req_en && !req_we)
            begin
                rd_valid_reg <= valid_reg[req_addr];
            end
        end
    end

    assign rd_busy  = rd_valid_reg ? rd_busy_reg  : '0;
    assign rd_count = rd_valid_reg ? rd_count_reg : '0;

endmodule

/* design/nfsd_ctrl.sv */
// Scan sequencer: walks the server memory, updates the chosen entry and the leader record.
module nfsd_ctrl
    import nfsd_pkg::*;
#(
    parameter int MAX_SERVERS = 32,
    parameter int TIME_BITS   = 32,
    parameter int IW          = 5
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [ACTIVE_W-1:0] active,
    input  logic                in_valid,
    output logic                in_ready,
    input  in_word_t            in_data,
    output logic                res_valid,
    input  logic                res_ready,
    output out_word_t           res,
    output logic                req_en,
    output logic                req_we,
    output logic [IW-1:0]       req_addr,
    output logic [TIME_BITS-1:0] wr_busy,
    output logic [COUNT_W-1:0]  wr_count,
    input  logic [TIME_BITS-1:0] rd_busy,
    input  logic [COUNT_W-1:0]  rd_count
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_UPDATE = 3'd2;
    localparam logic [2:0] ST_DONE   = 3'd3;

    localparam logic [63:0] TMASK = (64'd1 << TIME_BITS) - 64'd1;
    localparam logic [SRVN_W-1:0] MAXN = SRVN_W'(MAX_SERVERS);

    logic [2:0]             state_reg, state_next;
    logic [31:0]            arrive_reg, arrive_next;
    logic [31:0]            len_reg, len_next;
    logic [SRVN_W-1:0]      n_reg, n_next;
    logic [SRVN_W-1:0]      chk_reg, chk_next;
    logic [IW-1:0]          idx_reg, idx_next;
    logic [IW-1:0]          addr_reg, addr_next;
    logic [IW-1:0]          pick_reg, pick_next;
    logic                   served_reg, served_next;
    logic [TIME_BITS-1:0]   end_reg, end_next;
    logic [COUNT_W-1:0]     cnt_reg, cnt_next;
    logic [COUNT_W-1:0]     best_count_reg, best_count_next;
    logic [MAX_SERVERS-1:0] best_mask_reg, best_mask_next;

    logic [SRVN_W-1:0]      act7;
    logic [SRVN_W-1:0]      n_eff;
    logic [SRVN_W-1:0]      pref7;
    logic [SRVN_W-1:0]      start7;
    logic [IW-1:0]          start_idx;
    logic                   is_free;
    logic [32:0]            sum33;
    logic [63:0]            end64;
    logic [MAX_SERVERS-1:0] pick_onehot;
    logic [63:0]            mask64;
    logic [SRVN_W-1:0]      pick7;

    function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx,
                                               input logic [SRVN_W-1:0] n);
        logic [SRVN_W-1:0] idx7;
        idx7 = SRVN_W'(idx);
        if (idx7 == n - SRVN_W'(1))
        begin
            return '0;
        end
        return idx + IW'(1);
    endfunction

    assign act7   = SRVN_W'(active);
    assign n_eff  = (act7 == '0) ? SRVN_W'(1) : ((act7 > MAXN) ? MAXN : act7);
    assign pref7  = SRVN_W'(in_data.preferred_server);
    assign start7 = (pref7 < n_eff) ? pref7 : '0;
    assign start_idx = start7[IW-1:0];

    assign is_free = 64'(rd_busy) <= 64'(arrive_reg);
    assign sum33   = {1'b0, arrive_reg} + {1'b0, len_reg};
    assign end64   = (64'(sum33) > TMASK) ? TMASK : 64'(sum33);
    assign pick_onehot = MAX_SERVERS'(1) << pick_reg;

    always_comb
    begin
        state_next      = state_reg;
        arrive_next     = arrive_reg;
        len_next        = len_reg;
        n_next          = n_reg;
        chk_next        = chk_reg;
        idx_next        = idx_reg;
        addr_next       = addr_reg;
        pick_next       = pick_reg;
        served_next     = served_reg;
        end_next        = end_reg;
        cnt_next        = cnt_reg;
        best_count_next = best_count_reg;
        best_mask_next  = best_mask_reg;
        in_ready        = 1'b0;
        res_valid       = 1'b0;
        req_en          = 1'b0;
        req_we          = 1'b0;
        req_addr        = idx_reg;
        wr_busy         = end_reg;
        wr_count        = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    arrive_next = in_data.arrival_time & TMASK[31:0];
                    len_next    = in_data.service_length & TMASK[31:0];
                    n_next      = n_eff;
                    chk_next    = '0;
                    addr_next   = start_idx;
                    idx_next    = next_idx(start_idx, n_eff);
                    req_en      = 1'b1;
                    req_addr    = start_idx;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (is_free)
                begin
                    pick_next   = addr_reg;
                    served_next = 1'b1;
                    end_next    = end64[TIME_BITS-1:0];
                    cnt_next    = (rd_count == COUNT_MAX) ? COUNT_MAX
                                                          : rd_count + COUNT_W'(1);
                    state_next  = ST_UPDATE;
                end
                else if (chk_reg == n_reg - SRVN_W'(1))
                begin
                    pick_next   = '0;
                    served_next = 1'b0;
                    state_next  = ST_DONE;
                end
                else
                begin
                    req_en    = 1'b1;
                    req_addr  = idx_reg;
                    addr_next = idx_reg;
                    idx_next  = next_idx(idx_reg, n_reg);
                    chk_next  = chk_reg + SRVN_W'(1);
                end
            end
            ST_UPDATE:
            begin
                req_en   = 1'b1;
                req_we   = 1'b1;
                req_addr = pick_reg;
                if (cnt_reg > best_count_reg)
                begin
                    best_count_next = cnt_reg;
                    best_mask_next  = pick_onehot;
                end
                else if (cnt_reg == best_count_reg)
                begin
                    best_mask_next = best_mask_reg | pick_onehot;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign mask64 = 64'(best_mask_reg);
    assign pick7  = SRVN_W'(pick_reg);

    always_comb
    begin
        res.served          = served_reg;
        res.assigned_server = pick7[4:0];
        res.top_count       = best_count_reg;
        res.leader_mask     = mask64[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            best_count_reg <= '0;
            best_mask_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            best_count_reg <= best_count_next;
            best_mask_reg  <= best_mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        arrive_reg <= arrive_next;
        len_reg    <= len_next;
        n_reg      <= n_next;
        chk_reg    <= chk_next;
        idx_reg    <= idx_next;
        addr_reg   <= addr_next;
        pick_reg   <= pick_next;
        served_reg <= served_next;
        end_reg    <= end_next;
        cnt_reg    <= cnt_next;
    end

endmodule

/* design/next_free_server_dispatch.sv */
// Top level of the next-free-server dispatcher: register port, output register, core.
// A word is scanned until a free entry is found or all n active entries are checked (a drop).
// A new input word is taken only after the previous result has left the scan sequencer.
// The scan reads one server entry a cycle from the state memory's single port.
// Reset clears the entry valid bits and leader record and sets the register to 32 at once; no clearing pass.
// The next input word is taken while a finished result waits in the output register.
module next_free_server_dispatch
    import nfsd_pkg::*;
#(
    parameter int MAX_SERVERS = 32,
    parameter int TIME_BITS   = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_word_t           in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output out_word_t          out_data
);

    localparam int IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

    logic [ACTIVE_W-1:0]  active_reg;
    logic                 out_valid_reg;
    out_word_t            out_data_reg;
    logic                 res_valid;
    logic                 res_ready;
    out_word_t            res;
    logic                 req_en;
    logic                 req_we;
    logic [IW-1:0]        req_addr;
    logic [TIME_BITS-1:0] wr_busy;
    logic [COUNT_W-1:0]   wr_count;
    logic [TIME_BITS-1:0] rd_busy;
    logic [COUNT_W-1:0]   rd_count;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_ACTIVE) ? 32'(active_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_ACTIVE))
        begin
            active_reg <= pwdata[ACTIVE_W-1:0];
        end
    end

    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    nfsd_ctrl #(
        .MAX_SERVERS (MAX_SERVERS),
        .TIME_BITS   (TIME_BITS),
        .IW          (IW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .active    (active_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .req_en    (req_en),
        .req_we    (req_we),
        .req_addr  (req_addr),
        .wr_busy   (wr_busy),
        .wr_count  (wr_count),
        .rd_busy   (rd_busy),
        .rd_count  (rd_count)
    );

    nfsd_store #(
        .DEPTH (MAX_SERVERS),
        .IW    (IW),
        .TW    (TIME_BITS)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_en   (req_en),
        .req_we   (req_we),
        .req_addr (req_addr),
        .wr_busy  (wr_busy),
        .wr_count (wr_count),
        .rd_busy  (rd_busy),
        .rd_count (rd_count)
    );

endmodule

/* design/nfsd_check.sv */
// Port-level checker for the dispatcher, bound to the top level.
module nfsd_check
    import nfsd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_word_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_data
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input word dropped or changed before it was taken");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word dropped or changed while stalled");

    a_drop_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.served |-> out_data.assigned_server == 5'd0)
        else $error("dropped request reports a server index");

    a_served_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.served |-> out_data.top_count != 32'd0)
        else $error("served request leaves top count at zero");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while the previous word is still in the scan");

endmodule

bind next_free_server_dispatch nfsd_check u_nfsd_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

/* dv/next_free_server_dispatch_tb.sv */
// Self-checking testbench for the next-free-server dispatcher: directed and random request words.
module next_free_server_dispatch_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nfsd_pkg::*;

    localparam int NUM_SERVERS  = 32;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_WORDS  = 85;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PULSE} rx_mode_t;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr    = '0;
    logic [31:0]        pwdata   = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    in_word_t           in_data  = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    out_word_t          out_data;

    in_word_t  request_q[$];
    out_word_t grant_q[$];

    logic [31:0]         busy_until [NUM_SERVERS];
    logic [31:0]         handled [NUM_SERVERS];
    logic [31:0]         best_count;
    logic [31:0]         best_mask;
    logic [ACTIVE_W-1:0] active_cfg;
    logic [31:0]         now_t;

    out_word_t want_w;
    int        fault_count = 0;
    int        words_sent  = 0;
    int        cycle_count = 0;
    int        burst_left  = 0;
    int        gap_left    = 0;
    int        mode_left   = 0;
    int        hold_left   = 0;
    int        holds_done  = 0;
    rx_mode_t  stall_mode  = RX_OPEN;

    next_free_server_dispatch uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic out_word_t pick_server(input in_word_t w);
        int          n;
        int          i;
        int          pick;
        bit          found;
        logic [32:0] sum;
        logic [31:0] calls;
        out_word_t   r;
        n = (active_cfg == 0) ? 1 : (active_cfg > NUM_SERVERS) ? NUM_SERVERS : int'(active_cfg);
        found = 1'b0;
        pick = 0;
        for (i = int'(w.preferred_server); i < n && !found; i++)
        begin
            if (busy_until[i] <= w.arrival_time)
            begin
                found = 1'b1;
                pick = i;
            end
        end
        for (i = 0; i < n && !found; i++)
        begin
            if (busy_until[i] <= w.arrival_time)
            begin
                found = 1'b1;
                pick = i;
            end
        end
        if (found)
        begin
            sum = {1'b0, w.arrival_time} + {1'b0, w.service_length};
            busy_until[pick] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            calls = handled[pick];
            if (calls != COUNT_MAX)
                calls = calls + 1;
            handled[pick] = calls;
            if (calls > best_count)
            begin
                best_count = calls;
                best_mask = '0;
            end
            if (calls == best_count)
                best_mask[pick] = 1'b1;
        end
        r.served          = found;
        r.assigned_server = found ? 5'(pick) : 5'd0;
        r.top_count       = best_count;
        r.leader_mask     = best_mask;
        return r;
    endfunction

    function automatic string word_text(input out_word_t w);
        return $sformatf("served=%0b server=%0d top=%0d mask=%h",
                         w.served, w.assigned_server, w.top_count, w.leader_mask);
    endfunction

    task automatic log_fault(input string what, input out_word_t want, input out_word_t got);
        fault_count++;
        if (fault_count <= 10)
            $display("%s: expected %s, got %s", what, word_text(want), word_text(got));
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (request_q.size() != 0 || in_valid || grant_q.size() != 0);
        @(posedge clk);
    endtask

    task automatic set_active(input logic [ACTIVE_W-1:0] v);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ACTIVE;
        pwdata  <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        active_cfg = v;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== 32'(v))
        begin
            fault_count++;
            if (fault_count <= 10)
                $display("register read: expected %0d, got %0d", v, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic queue_word(input logic [4:0] pref, input logic [31:0] arr,
                              input logic [31:0] len);
        in_word_t w;
        w.preferred_server = pref;
        w.arrival_time     = arr;
        w.service_length   = len;
        request_q.push_back(w);
    endtask

    task automatic queue_random(input int len_max);
        logic [31:0] arr;
        logic [31:0] len;
        logic [32:0] step;
        if ($urandom_range(0, 19) == 0)
            arr = $urandom_range(0, now_t);
        else
        begin
            step = {1'b0, now_t} + 33'($urandom_range(0, 3));
            now_t = step[32] ? 32'hFFFF_FFFF : step[31:0];
            arr = now_t;
        end
        case ($urandom_range(0, 31))
            0: len = $urandom >> $urandom_range(8, 31);
            1: len = '0;
            default: len = $urandom_range(0, len_max);
        endcase
        queue_word(5'($urandom_range(0, 31)), arr, len);
    endtask

    // driver: bursts of words with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                grant_q.push_back(pick_server(in_data));
                words_sent <= words_sent + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (request_q.size() > 0)
                begin
                    in_data  <= request_q.pop_front();
                    in_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern, plus two long holds while words are still queued
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (holds_done < 2 && words_sent >= 250 + 450 * holds_done && request_q.size() > 20)
        begin
            holds_done++;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 128);
            end
            else
                mode_left--;
            case (stall_mode)
                RX_OPEN:   out_ready <= 1'b1;
                RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
                default:   out_ready <= ((cycle_count / 8) % 2 == 0);
            endcase
        end
    end

    // monitor: check each word against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (grant_q.size() == 0)
                log_fault("unexpected word", '0, out_data);
            else
            begin
                want_w = grant_q.pop_front();
                if (out_data.served !== want_w.served
                    || out_data.assigned_server !== want_w.assigned_server
                    || out_data.top_count !== want_w.top_count
                    || out_data.leader_mask !== want_w.leader_mask)
                    log_fault("mismatch", want_w, out_data);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin : stimulus
        int                  p;
        int                  k;
        int                  n_cfg;
        int                  len_max;
        logic [ACTIVE_W-1:0] cfg;
        logic [ACTIVE_W-1:0] plan [12];
        plan = '{6'd1, 6'd2, 6'd0, 6'd3, 6'd32, 6'd63, 6'd4, 6'd33, 6'd8, 6'd16, 6'd31, 6'd32};
        for (k = 0; k < NUM_SERVERS; k++)
        begin
            busy_until[k] = '0;
            handled[k] = '0;
        end
        best_count = '0;
        best_mask  = '0;
        active_cfg = ACTIVE_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset width: all 32 servers in use
        queue_word(5'd0,  32'd0,  32'd0);
        queue_word(5'd31, 32'd0,  32'hFFFF_FFFF);
        queue_word(5'd31, 32'd0,  32'd5);
        queue_word(5'd5,  32'd10, 32'd100);
        queue_word(5'd5,  32'd20, 32'd1);
        queue_word(5'd30, 32'd40, 32'hFFFF_FFF0);
        queue_word(5'd30, 32'd50, 32'd7);
        queue_word(5'd0,  32'd3,  32'd0);
        set_active(6'd1);
        queue_word(5'd31, 32'd1000, 32'd10);
        queue_word(5'd0,  32'd1005, 32'd1);
        queue_word(5'd0,  32'd1010, 32'd0);
        set_active(6'd0);
        queue_word(5'd17, 32'd1010, 32'd3);
        queue_word(5'd0,  32'd1011, 32'd2);
        set_active(6'd2);
        queue_word(5'd1,  32'd1020, 32'd50);
        queue_word(5'd1,  32'd1021, 32'd50);
        queue_word(5'd0,  32'd1022, 32'd1);
        set_active(6'd63);
        queue_word(5'd20, 32'd1030, 32'd5);
        queue_word(5'd31, 32'd1031, 32'd0);

        now_t = 32'd2000;
        for (p = 0; p < 12; p++)
        begin
            cfg = (p % 4 == 3) ? 6'($urandom_range(0, 63)) : plan[p];
            set_active(cfg);
            n_cfg = (cfg == 0) ? 1 : (cfg > NUM_SERVERS) ? NUM_SERVERS : int'(cfg);
            len_max = $urandom_range(n_cfg / 2 + 1, 4 * n_cfg + 8);
            if (p == 10)
                now_t = 32'h8000_0000 + $urandom_range(0, 32'h0FFF_FFFF);
            else if (p == 11)
                now_t = 32'hFFFF_F000 + $urandom_range(0, 32'h0000_0800);
            else
                now_t = now_t + $urandom_range(1 << 24, 1 << 25);
            for (k = 0; k < PHASE_WORDS; k++)
                queue_random(len_max);
            if (p == 11)
            begin
                queue_word(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                queue_word(5'd0,  32'hFFFF_FFFF, 32'd0);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
